// ===== design/hkc_pkg.sv =====
package hkc_pkg;

  // default table depth
  localparam int MAX_KEYS_DEF = 64;

  // field widths
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int DAT_W = 32;
  localparam int KEY_W = 4 * DAT_W;
  localparam int S_TDATA_W = 168;
  localparam int M_TDATA_W = 40;

  // command codes carried on tuser
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  // one classified item travelling from front to back
  typedef struct packed {
    logic        is_eval;
    logic        slot_ok;
    logic [5:0]  index;
    logic [31:0] ktime;
    logic [31:0] kvalue;
    logic [31:0] kin;
    logic [31:0] kout;
    logic [31:0] etime;
  } item_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_SRCH,
    ST_RD_K0,
    ST_DIV,
    ST_MUL,
    ST_FINISH
  } state_e;

  // multiply steps of the shared multiplier
  localparam logic [3:0] MS_TT   = 4'd0;
  localparam logic [3:0] MS_T2T  = 4'd1;
  localparam logic [3:0] MS_M0   = 4'd2;
  localparam logic [3:0] MS_M1   = 4'd3;
  localparam logic [3:0] MS_H00  = 4'd4;
  localparam logic [3:0] MS_H10L = 4'd5;
  localparam logic [3:0] MS_H10H = 4'd6;
  localparam logic [3:0] MS_H01  = 4'd7;
  localparam logic [3:0] MS_H11L = 4'd8;
  localparam logic [3:0] MS_H11H = 4'd9;

  // index of the last quotient bit of the segment fraction
  localparam logic [3:0] DIV_LAST = 4'd15;

endpackage

// ===== design/hkc_ram.sv =====
module hkc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hkc_front.sv =====
module hkc_front #(
  parameter int MAX_KEYS = hkc_pkg::MAX_KEYS_DEF
) (
  input  logic [hkc_pkg::S_TDATA_W-1:0] tdata_i,
  input  logic                          tuser_i,
  output hkc_pkg::item_t                item_o
);
  import hkc_pkg::*;

  logic [5:0] idx;

  // unpack the transfer and classify it
  always_comb begin
    idx            = tdata_i[5:0];
    item_o.is_eval = (tuser_i == CMD_EVAL);
    item_o.index   = idx;
    item_o.slot_ok = ({26'b0, idx} < 32'(MAX_KEYS));
    item_o.ktime   = tdata_i[37:6];
    item_o.kvalue  = tdata_i[69:38];
    item_o.kin     = tdata_i[101:70];
    item_o.kout    = tdata_i[133:102];
    item_o.etime   = tdata_i[165:134];
  end

endmodule

// ===== design/hkc_queue.sv =====
module hkc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hkc_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output hkc_pkg::item_t item_o
);
  import hkc_pkg::*;

  item_t      slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rptr_q];

  // pointer and fill update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== design/hkc_back.sv =====
module hkc_back #(
  parameter int MAX_KEYS = hkc_pkg::MAX_KEYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hkc_pkg::CNT_W-1:0]   key_count_i,
  input  logic                        q_valid_i,
  input  hkc_pkg::item_t              q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [31:0]                 out_value_o,
  output logic [5:0]                  out_seg_o
);
  import hkc_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);

  state_e state_q, state_d;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;
  logic signed [31:0] rd_t, rd_p, rd_in, rd_out;

  logic signed [31:0] when_q, when_d;
  logic [CW-1:0]      n_q, n_d;
  logic [AW-1:0]      i_q, i_d;
  logic signed [31:0] p0_q, p0_d, out0_q, out0_d;
  logic signed [31:0] t1_q, t1_d, p1_q, p1_d, in1_q, in1_d;
  logic signed [32:0] dt_q, dt_d;
  logic [32:0]        rem_q, rem_d;
  logic [15:0]        quo_q, quo_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [3:0]         step_q, step_d;
  logic               phase_q, phase_d;
  logic signed [67:0] prod_q, prod_d;
  logic [15:0]        t2_q, t2_d, t3_q, t3_d;
  logic signed [48:0] m0_q, m0_d, m1_q, m1_d;
  logic [63:0]        acc_q, acc_d;
  logic [31:0]        res_q, res_d;
  logic [AW-1:0]      seg_q, seg_d;
  logic               from_acc_q, from_acc_d;

  logic               ov_q, ov_d;
  logic [31:0]        ovl_q, ovl_d;
  logic [5:0]         ovs_q, ovs_d;

  logic signed [32:0] t0x, diff;
  logic [33:0]        r2, dt34;
  logic signed [19:0] t2s, t3s, h00, h10, h01, h11;
  logic signed [33:0] ma, mb;
  logic signed [47:0] scaled;
  logic [31:0]        sat_val;

  hkc_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(q_item_i.index)),
    .wdata_i({q_item_i.kout, q_item_i.kin, q_item_i.kvalue, q_item_i.ktime}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_t   = ram_rdata[31:0];
  assign rd_p   = ram_rdata[63:32];
  assign rd_in  = ram_rdata[95:64];
  assign rd_out = ram_rdata[127:96];

  // hermite basis from the fraction powers
  always_comb begin
    t2s = {4'b0, t2_q};
    t3s = {4'b0, t3_q};
    h00 = 20'sd2 * t3s - 20'sd3 * t2s + 20'sd65536;
    h10 = t3s - 20'sd2 * t2s + $signed({4'b0, quo_q});
    h01 = 20'sd3 * t2s - 20'sd2 * t3s;
    h11 = t3s - t2s;
  end

  // operand selection of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q)
      MS_TT: begin
        ma = {18'b0, quo_q};
        mb = {18'b0, quo_q};
      end
      MS_T2T: begin
        ma = {18'b0, t2_q};
        mb = {18'b0, quo_q};
      end
      MS_M0: begin
        ma = 34'(out0_q);
        mb = 34'(dt_q);
      end
      MS_M1: begin
        ma = 34'(in1_q);
        mb = 34'(dt_q);
      end
      MS_H00: begin
        ma = 34'(h00);
        mb = 34'(p0_q);
      end
      MS_H10L: begin
        ma = 34'(h10);
        mb = {10'b0, m0_q[23:0]};
      end
      MS_H10H: begin
        ma = 34'(h10);
        mb = 34'($signed(m0_q[48:24]));
      end
      MS_H01: begin
        ma = 34'(h01);
        mb = 34'(p1_q);
      end
      MS_H11L: begin
        ma = 34'(h11);
        mb = {10'b0, m1_q[23:0]};
      end
      MS_H11H: begin
        ma = 34'(h11);
        mb = 34'($signed(m1_q[48:24]));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // floor to q16.16 and saturate
  always_comb begin
    scaled = acc_q[63:16];
    if ((scaled[47:31] == '0) || (scaled[47:31] == '1)) begin
      sat_val = scaled[31:0];
    end else if (scaled[47]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    when_d     = when_q;
    n_d        = n_q;
    i_d        = i_q;
    p0_d       = p0_q;
    out0_d     = out0_q;
    t1_d       = t1_q;
    p1_d       = p1_q;
    in1_d      = in1_q;
    dt_d       = dt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    phase_d    = phase_q;
    prod_d     = prod_q;
    t2_d       = t2_q;
    t3_d       = t3_q;
    m0_d       = m0_q;
    m1_d       = m1_q;
    acc_d      = acc_q;
    res_d      = res_q;
    seg_d      = seg_q;
    from_acc_d = from_acc_q;
    ov_d       = ov_q;
    ovl_d      = ovl_q;
    ovs_d      = ovs_q;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = '0;
    t0x        = 33'(rd_t);
    diff       = 33'(when_q) - t0x;
    r2         = {rem_q, 1'b0};
    dt34       = {1'b0, dt_q};

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!q_item_i.is_eval) begin
            ram_we = q_item_i.slot_ok;
          end else begin
            when_d     = q_item_i.etime;
            n_d        = (32'(key_count_i) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_i);
            seg_d      = '0;
            from_acc_d = 1'b0;
            if (n_d == '0) begin
              res_d   = '0;
              state_d = ST_FINISH;
            end else begin
              ram_raddr = '0;
              state_d   = ST_RD_FIRST;
            end
          end
        end
      end
      ST_RD_FIRST: begin
        if ((n_q == CW'(1)) || (when_q <= rd_t)) begin
          res_d   = rd_p;
          state_d = ST_FINISH;
        end else begin
          ram_raddr = AW'(n_q - CW'(1));
          state_d   = ST_RD_LAST;
        end
      end
      ST_RD_LAST: begin
        if (when_q >= rd_t) begin
          res_d   = rd_p;
          seg_d   = AW'(n_q - CW'(1));
          state_d = ST_FINISH;
        end else begin
          i_d       = '0;
          ram_raddr = AW'(1);
          state_d   = ST_SRCH;
        end
      end
      // one key per cycle, data is key i+1
      ST_SRCH: begin
        if (rd_t <= when_q) begin
          i_d       = i_q + 1'b1;
          ram_raddr = AW'(i_q + AW'(2));
        end else begin
          t1_d      = rd_t;
          p1_d      = rd_p;
          in1_d     = rd_in;
          ram_raddr = i_q;
          state_d   = ST_RD_K0;
        end
      end
      ST_RD_K0: begin
        seg_d  = i_q;
        p0_d   = rd_p;
        out0_d = rd_out;
        dt_d   = 33'(t1_q) - t0x;
        rem_d  = diff;
        quo_d  = '0;
        cnt_d  = '0;
        if ((dt_d <= 0) || (diff < 0)) begin
          res_d   = rd_p;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DIV;
        end
      end
      // restoring division, one quotient bit a cycle
      ST_DIV: begin
        if (r2 >= dt34) begin
          rem_d = 33'(r2 - dt34);
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = r2[32:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DIV_LAST) begin
          step_d  = MS_TT;
          phase_d = 1'b0;
          state_d = ST_MUL;
        end
      end
      // multiply, then consume the registered product
      ST_MUL: begin
        if (!phase_q) begin
          prod_d  = ma * mb;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          step_d  = step_q + 4'd1;
          unique case (step_q)
            MS_TT:   t2_d  = prod_q[31:16];
            MS_T2T:  t3_d  = prod_q[31:16];
            MS_M0:   m0_d  = prod_q[64:16];
            MS_M1:   m1_d  = prod_q[64:16];
            MS_H00:  acc_d = prod_q[63:0];
            MS_H10L: acc_d = acc_q + prod_q[63:0];
            MS_H10H: acc_d = acc_q + {prod_q[39:0], 24'b0};
            MS_H01:  acc_d = acc_q + prod_q[63:0];
            MS_H11L: acc_d = acc_q + prod_q[63:0];
            MS_H11H: acc_d = acc_q + {prod_q[39:0], 24'b0};
            default: acc_d = acc_q;
          endcase
          if (step_q == MS_H11H) begin
            from_acc_d = 1'b1;
            state_d    = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ovl_d   = from_acc_q ? sat_val : res_q;
          ovs_d   = 6'(seg_q);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      step_q  <= MS_TT;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      step_q  <= step_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    when_q     <= when_d;
    n_q        <= n_d;
    i_q        <= i_d;
    p0_q       <= p0_d;
    out0_q     <= out0_d;
    t1_q       <= t1_d;
    p1_q       <= p1_d;
    in1_q      <= in1_d;
    dt_q       <= dt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    prod_q     <= prod_d;
    t2_q       <= t2_d;
    t3_q       <= t3_d;
    m0_q       <= m0_d;
    m1_q       <= m1_d;
    acc_q      <= acc_d;
    res_q      <= res_d;
    seg_q      <= seg_d;
    from_acc_q <= from_acc_d;
    ovl_q      <= ovl_d;
    ovs_q      <= ovs_d;
  end

  assign out_valid_o = ov_q;
  assign out_value_o = ovl_q;
  assign out_seg_o   = ovs_q;

endmodule

// ===== design/hermite_keyframe_curve_eval_core.sv =====
// write transfers: one per cycle while no evaluate is in progress, no result, written to the key table on pop
// evaluate: linear key search one key a cycle, 16-bit serial restoring divide, then ten
//   steps on the shared multiplier
// one evaluate at a time: the next queued item waits until the current result is registered
// reset: key_count clears to zero, queue and result register empty; the key table
//   is not cleared and holds no defined content until written
module hermite_keyframe_curve_eval_core #(
  parameter int MAX_KEYS = hkc_pkg::MAX_KEYS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hkc_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key_index, key_time, key_value, key_in_tangent, key_out_tangent, eval_time, pad
  input  logic [hkc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // curve_value, segment_index, pad
  output logic [hkc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import hkc_pkg::*;

  logic [CNT_W-1:0] key_count_q;
  item_t            f_item, q_item;
  logic             q_ready, q_valid, q_pop;
  logic [31:0]      out_value;
  logic [5:0]       out_seg;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_wdata_i;
    end
  end

  hkc_front #(
    .MAX_KEYS(MAX_KEYS)
  ) u_front (
    .tdata_i(s_axis_tdata),
    .tuser_i(s_axis_tuser),
    .item_o (f_item)
  );

  assign s_axis_tready = q_ready;

  hkc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid && q_ready),
    .item_i (f_item),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  hkc_back #(
    .MAX_KEYS(MAX_KEYS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_count_i(key_count_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_value_o(out_value),
    .out_seg_o  (out_seg)
  );

  assign m_axis_tdata = {2'b00, out_seg, out_value};

endmodule

// ===== design/hkc_checker.sv =====
module hkc_checker #(
  parameter int MAX_KEYS = hkc_pkg::MAX_KEYS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hkc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // no result shown while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // segment index lies inside the table
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({26'b0, m_axis_tdata[37:32]} < 32'(MAX_KEYS)))
    else $error("segment index beyond table");

  // padding stays zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:38] == 2'b00))
    else $error("result padding not zero");

endmodule

bind hermite_keyframe_curve_eval_core hkc_checker #(.MAX_KEYS(MAX_KEYS)) u_hkc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
